// File: design/utf8_decode_validate_top_assert.svh
// Assertion macros for the UTF-8 decoder checker.
// Depends on a clk and an active-low arst_n in the scope of use.
`ifndef UTF8_DECODE_VALIDATE_TOP_ASSERT_SVH
`define UTF8_DECODE_VALIDATE_TOP_ASSERT_SVH
// Condition must hold in the same cycle as the trigger.
`define U8DV_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);
// Condition must hold in the cycle after the trigger.
`define U8DV_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`endif

// File: design/utf8dv_pkg.sv
// Shared types and constants for the UTF-8 decoder/validator.
// No dependencies.
package utf8dv_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned CpW    = 21;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = 2;

	// verdict codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_LEAD = 3'd1;
	localparam logic [2:0] ST_BAD_CONT = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	// byte classes
	localparam logic [2:0] CLS_ASCII = 3'd0;
	localparam logic [2:0] CLS_LEAD2 = 3'd1;
	localparam logic [2:0] CLS_LEAD3 = 3'd2;
	localparam logic [2:0] CLS_LEAD4 = 3'd3;
	localparam logic [2:0] CLS_CONT  = 3'd4;
	localparam logic [2:0] CLS_BAD   = 3'd5;

	// register indexes
	localparam logic [1:0] REG_STRICT = 2'd0;
	localparam logic [1:0] REG_BOM    = 2'd1;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] cls;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [CpW-1:0]    cp;
		logic              rdy;
		logic [2:0]        status;
		logic              done;
		logic [CountW-1:0] count;
	} result_t;

endpackage

// File: design/utf8dv_front.sv
// Front end: takes input words and tags each byte with its class.
// Depends on utf8dv_pkg.
module utf8dv_front import utf8dv_pkg::*; (
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       wr_en,
	output item_t      wr_item
);

	logic [2:0] cls;

	always_comb begin
		if (data_byte[7] == 1'b0) begin
			cls = CLS_ASCII;
		end else if (data_byte[7:6] == 2'b10) begin
			cls = CLS_CONT;
		end else if (data_byte[7:5] == 3'b110) begin
			cls = CLS_LEAD2;
		end else if (data_byte[7:4] == 4'b1110) begin
			cls = CLS_LEAD3;
		end else if (data_byte[7:3] == 5'b11110) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_BAD;
		end
	end

	assign wr_en        = push && !q_full;
	assign wr_item.data = data_byte;
	assign wr_item.cls  = cls;
	assign wr_item.last = last_byte;

endmodule

// File: design/utf8dv_queue.sv
// Short queue of classified bytes between front and back.
// Depends on utf8dv_pkg.
module utf8dv_queue import utf8dv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	item_t          mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   cnt_q;

	assign full    = (cnt_q == (QAw+1)'(QDepth));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/utf8dv_back.sv
// Back end: decoder state, checks, config registers and result buffer.
// Depends on utf8dv_pkg.
module utf8dv_back import utf8dv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  item_t      item,
	output logic       item_take,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       pop,
	output logic       empty,
	output result_t    res
);

	logic              strict_q;
	logic              bom_q;
	logic [1:0]        pend_q;
	logic [CpW-1:0]    acc_q;
	logic [2:0]        len_q;
	logic              start_q;
	logic [2:0]        err_q;
	logic [CountW-1:0] cnt_q;

	logic [1:0]        pend_n;
	logic [CpW-1:0]    acc_n;
	logic [2:0]        len_n;
	logic              start_n;
	logic [2:0]        err_n;
	logic [CountW-1:0] cnt_n;
	logic              complete;
	logic              ready;
	logic              in_rng;
	logic              is_bom;
	logic              emit;
	result_t           res_n;

	result_t           ob_q [2];
	logic              ob_wp_q;
	logic              ob_rp_q;
	logic [1:0]        ob_cnt_q;
	logic              pop_fire;
	logic              ob_we;

	assign pop_fire  = pop && !empty;
	assign empty     = (ob_cnt_q == 2'd0);
	assign res       = ob_q[ob_rp_q];
	assign item_take = item_valid && (ob_cnt_q != 2'd2 || pop_fire);
	assign ob_we     = item_take && emit;

	always_comb begin
		pend_n   = pend_q;
		acc_n    = acc_q;
		len_n    = len_q;
		start_n  = start_q;
		err_n    = err_q;
		cnt_n    = cnt_q;
		complete = 1'b0;
		ready    = 1'b0;
		in_rng   = 1'b1;
		is_bom   = 1'b0;
		res_n.cp = '0;

		if (err_q == ST_OK) begin
			if (pend_q == 2'd0) begin
				case (item.cls)
					CLS_ASCII: begin
						acc_n    = CpW'(item.data);
						len_n    = 3'd1;
						complete = 1'b1;
					end
					CLS_LEAD2: begin
						acc_n  = CpW'(item.data[4:0]);
						len_n  = 3'd2;
						pend_n = 2'd1;
					end
					CLS_LEAD3: begin
						acc_n  = CpW'(item.data[3:0]);
						len_n  = 3'd3;
						pend_n = 2'd2;
					end
					CLS_LEAD4: begin
						acc_n  = CpW'(item.data[2:0]);
						len_n  = 3'd4;
						pend_n = 2'd3;
					end
					default: begin
						err_n = ST_BAD_LEAD;
					end
				endcase
			end else if (strict_q && item.data[7:6] != 2'b10) begin
				err_n = ST_BAD_CONT;
			end else begin
				acc_n  = {acc_q[CpW-7:0], item.data[5:0]};
				pend_n = pend_q - 2'd1;
				complete = (pend_q == 2'd1);
			end

			if (complete) begin
				case (len_n)
					3'd2:    in_rng = acc_n inside {[21'h80 : 21'h7ff]};
					3'd3:    in_rng = acc_n inside {[21'h800 : 21'hffff]};
					3'd4:    in_rng = acc_n inside {[21'h10000 : 21'h10ffff]};
					default: in_rng = 1'b1;
				endcase
				is_bom = bom_q && start_q && len_n == 3'd3 && acc_n == 21'hfeff;
				if (strict_q && !in_rng) begin
					err_n = ST_RANGE;
				end else if (is_bom) begin
					start_n = 1'b0;
				end else begin
					ready    = 1'b1;
					res_n.cp = acc_n;
					start_n  = 1'b0;
					if (cnt_q != {CountW{1'b1}}) begin
						cnt_n = cnt_q + 1'b1;
					end
				end
				acc_n = '0;
				len_n = '0;
			end
			if (err_n != ST_OK) begin
				pend_n = '0;
				acc_n  = '0;
				len_n  = '0;
			end
		end

		// final byte inside an unfinished character
		if (item.last && err_n == ST_OK && pend_n != 2'd0) begin
			err_n = ST_TRUNC;
		end

		emit         = ready || item.last;
		res_n.rdy    = ready;
		res_n.status = item.last ? err_n : ST_OK;
		res_n.done   = item.last;
		res_n.count  = cnt_n;

		// end of string: drop all string state
		if (item.last) begin
			pend_n  = '0;
			acc_n   = '0;
			len_n   = '0;
			start_n = 1'b1;
			err_n   = ST_OK;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_we) begin
			ob_q[ob_wp_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
			bom_q    <= 1'b1;
			pend_q   <= '0;
			acc_q    <= '0;
			len_q    <= '0;
			start_q  <= 1'b1;
			err_q    <= ST_OK;
			cnt_q    <= '0;
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_STRICT) begin
				strict_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BOM) begin
				bom_q <= cfg_data;
			end
			if (item_take) begin
				pend_q  <= pend_n;
				acc_q   <= acc_n;
				len_q   <= len_n;
				start_q <= start_n;
				err_q   <= err_n;
				cnt_q   <= cnt_n;
			end
			if (ob_we) begin
				ob_wp_q <= ~ob_wp_q;
			end
			if (pop_fire) begin
				ob_rp_q <= ~ob_rp_q;
			end
			if (ob_we && !pop_fire) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (pop_fire && !ob_we) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: design/utf8_decode_validate_top.sv
// Top level of the UTF-8 decoder/validator.
// Depends on utf8dv_pkg, utf8dv_front, utf8dv_queue and utf8dv_back.
//
// Usage:
//  Input channel: a queue write. Drive data_byte/last_byte and raise push;
//  the word is taken on an edge where push is high and full is low.
//  last_byte marks the final byte of a string.
//  Result channel: a queue read. While empty is low the oldest result sits on
//  code_point/char_ready/status/done_res/char_count; raise pop to take it.
//  A byte yields a result when it completes an accepted character (no skipped
//  BOM, no strict range error), when it is the final byte, or both; others none.
//  Config channel: cfg_valid/cfg_ready with cfg_index (0 strict_mode,
//  1 skip_bom) and cfg_data; cfg_ready is always high. Write only while idle.
//  A taken byte is registered in the byte queue, then its result in the result buffer.
//  Throughput: one byte per cycle while the result buffer has room, set by the
//  back-end decode update; front and back are parted by a 4-word byte queue.
//  Stall: when pop stays low the 2-word result buffer fills, then the byte
//  queue fills and full rises; nothing is lost.
//  Reset: arst_n clears all string state and queues; strict_mode and
//  skip_bom return to 1.
module utf8_decode_validate_top import utf8dv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              empty,
	input  logic              pop,
	output logic [CpW-1:0]    code_point,
	output logic              char_ready,
	output logic [2:0]        status,
	output logic              done_res,
	output logic [CountW-1:0] char_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data
);

	logic    q_wr;
	item_t   q_wr_item;
	logic    q_full;
	logic    q_rd;
	item_t   q_rd_item;
	logic    q_empty;
	result_t res;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// classify incoming bytes
	utf8dv_front u_front (
		.push      (push),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.wr_en     (q_wr),
		.wr_item   (q_wr_item)
	);

	// hold classified bytes until the back end takes them
	utf8dv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// decode, check and buffer results
	utf8dv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (q_rd_item),
		.item_take  (q_rd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign code_point = res.cp;
	assign char_ready = res.rdy;
	assign status     = res.status;
	assign done_res   = res.done;
	assign char_count = res.count;

endmodule

// File: design/utf8dv_checker.sv
// Port-level checker for the UTF-8 decoder/validator, bound to the top level.
// Depends on utf8dv_pkg and utf8_decode_validate_top_assert.svh.
`include "utf8_decode_validate_top_assert.svh"
module utf8dv_checker import utf8dv_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [CpW-1:0]    code_point,
	input logic              char_ready,
	input logic [2:0]        status,
	input logic              done_res,
	input logic [CountW-1:0] char_count
);

	`U8DV_ASSERT_NOW(a_status_only_done, !empty && !done_res, status == ST_OK, "status without done")
	`U8DV_ASSERT_NOW(a_cp_zero_idle, !empty && !char_ready, code_point == '0, "stray code point")
	`U8DV_ASSERT_NOW(a_status_legal, !empty, status <= ST_RANGE, "status out of range")
	`U8DV_ASSERT_NOW(a_count_nonzero, !empty && char_ready, char_count != '0, "char without count")
	`U8DV_ASSERT_NEXT(a_hold_stall, !empty && !pop, !empty && $stable(code_point), "result dropped")

endmodule

bind utf8_decode_validate_top utf8dv_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.code_point (code_point),
	.char_ready (char_ready),
	.status     (status),
	.done_res   (done_res),
	.char_count (char_count)
);
